>>> hdl/hpss_pkg.sv
// Shared types, register map and arithmetic helpers for the heading PD servo steering block.
// Used by the register file, the PD pipeline, the duty stage and the top level.
// Depends on nothing.
package hpss_pkg;

   // Register map: byte address is four times the register index.
   localparam int CSR_ADDR_W = 5;
   localparam logic [2:0] REG_SERVO_MID    = 3'd0;
   localparam logic [2:0] REG_RANGE_UP     = 3'd1;
   localparam logic [2:0] REG_RANGE_DOWN   = 3'd2;
   localparam logic [2:0] REG_DUTY_FLOOR   = 3'd3;
   localparam logic [2:0] REG_DUTY_CEILING = 3'd4;
   localparam logic [2:0] REG_GAIN_P       = 3'd5;
   localparam logic [2:0] REG_GAIN_D       = 3'd6;
   localparam logic [2:0] REG_STEER_NEGATE = 3'd7;

   // Register reset values.
   localparam logic [15:0] RST_DUTY_CEILING = 16'hFFFF;
   localparam logic [15:0] RST_GAIN_P       = 16'd46;
   localparam logic [15:0] RST_GAIN_D       = 16'd400;

   // Number of register stages in the PD pipeline (input register through offset stage).
   localparam int PIPE_STAGES = 6;

   // Heading arithmetic: a full turn in centidegrees.
   localparam logic signed [18:0] FULL_TURN = 19'sd36000;

   // Division by 1000 of a magnitude below 2^25, done as a multiply by a
   // rounded-up reciprocal and a right shift; exact over that range.
   localparam int               RECIP_SHIFT = 35;
   localparam logic [25:0]      RECIP_MULT  = 26'd34359739;
   localparam logic [34:0]      SAT_NUM     = 35'd32768000;
   localparam logic signed [15:0] OFFSET_MAX = 16'sd32767;
   localparam logic signed [15:0] OFFSET_MIN = -16'sd32768;

   typedef struct packed {
      logic [15:0] servo_mid;
      logic [14:0] range_up;
      logic [14:0] range_down;
      logic [15:0] duty_floor;
      logic [15:0] duty_ceiling;
      logic [15:0] gain_p;
      logic [15:0] gain_d;
      logic        steer_negate;
   } hpss_cfg_type;

   typedef struct packed {
      logic [PIPE_STAGES-1:0] stage_valid;
   } hpss_stat_type;

   // Unsigned heading error, taking the short way around when the signs differ.
   function automatic logic [15:0] hpss_heading_err(input logic signed [15:0] goal,
                                                    input logic signed [15:0] yaw);
      logic signed [18:0] g;
      logic signed [18:0] y;
      logic signed [18:0] a;
      logic signed [18:0] b;
      logic signed [18:0] e;
      g = 19'(goal);
      y = 19'(yaw);
      if (goal[15] == yaw[15]) begin
         a = g - y;
         e = a[18] ? -a : a;
      end else if (goal[15]) begin
         a = FULL_TURN - y + g;
         b = y - g;
         e = (a < b) ? a : b;
      end else begin
         a = FULL_TURN - g + y;
         b = g - y;
         e = (a < b) ? a : b;
      end
      if (e < 19'sd0) begin
         e = 19'sd0;
      end else if (e > 19'sd65535) begin
         e = 19'sd65535;
      end
      return e[15:0];
   endfunction

endpackage

>>> hdl/hpss_intf.sv
// Valid/ready channel interfaces for the heading PD servo steering block.
// The request channel carries headings and the enable; the response channel carries duty and error.
// Depends on nothing.
interface hpss_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] goal_heading;
   logic signed [15:0] yaw_heading;
   logic               pd_enable;

   modport source (output valid, output goal_heading, output yaw_heading, output pd_enable,
                   input ready);
   modport sink   (input valid, input goal_heading, input yaw_heading, input pd_enable,
                   output ready);
endinterface

interface hpss_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] duty;
   logic [15:0] heading_error;

   modport source (output valid, output duty, output heading_error, input ready);
   modport sink   (input valid, input duty, input heading_error, output ready);
endinterface

>>> hdl/hpss_csr.sv
// APB-style configuration register file for the heading PD servo steering block.
// Depends on hpss_pkg for the register map, reset values and the configuration struct.
module hpss_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [hpss_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [31:0]                      pwdata,
   output logic [31:0]                      prdata,
   output logic                             pready,
   output hpss_pkg::hpss_cfg_type           cfg
);
   import hpss_pkg::*;

   hpss_cfg_type cfg_ff;
   hpss_cfg_type cfg_in;
   logic         wr_en;
   logic [2:0]   reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite && pready;
   assign reg_idx = paddr[CSR_ADDR_W-1:2];

   // Write decode: the addressed register takes the low bits of the write data.
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_SERVO_MID:    cfg_in.servo_mid    = pwdata[15:0];
            REG_RANGE_UP:     cfg_in.range_up     = pwdata[14:0];
            REG_RANGE_DOWN:   cfg_in.range_down   = pwdata[14:0];
            REG_DUTY_FLOOR:   cfg_in.duty_floor   = pwdata[15:0];
            REG_DUTY_CEILING: cfg_in.duty_ceiling = pwdata[15:0];
            REG_GAIN_P:       cfg_in.gain_p       = pwdata[15:0];
            REG_GAIN_D:       cfg_in.gain_d       = pwdata[15:0];
            REG_STEER_NEGATE: cfg_in.steer_negate = pwdata[0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.servo_mid    <= '0;
         cfg_ff.range_up     <= '0;
         cfg_ff.range_down   <= '0;
         cfg_ff.duty_floor   <= '0;
         cfg_ff.duty_ceiling <= RST_DUTY_CEILING;
         cfg_ff.gain_p       <= RST_GAIN_P;
         cfg_ff.gain_d       <= RST_GAIN_D;
         cfg_ff.steer_negate <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read mux returns the zero-extended register value.
   always_comb begin
      unique case (reg_idx)
         REG_SERVO_MID:    prdata = {16'd0, cfg_ff.servo_mid};
         REG_RANGE_UP:     prdata = {17'd0, cfg_ff.range_up};
         REG_RANGE_DOWN:   prdata = {17'd0, cfg_ff.range_down};
         REG_DUTY_FLOOR:   prdata = {16'd0, cfg_ff.duty_floor};
         REG_DUTY_CEILING: prdata = {16'd0, cfg_ff.duty_ceiling};
         REG_GAIN_P:       prdata = {16'd0, cfg_ff.gain_p};
         REG_GAIN_D:       prdata = {16'd0, cfg_ff.gain_d};
         REG_STEER_NEGATE: prdata = {31'd0, cfg_ff.steer_negate};
         default:          prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

>>> hdl/hpss_pd_pipe.sv
// PD pipeline: input register, heading error, gain products, sum and saturation test,
// reciprocal divide by 1000, and the steering offset stage that holds the offset state.
// Depends on hpss_pkg for the configuration struct, constants and the heading error function.
module hpss_pd_pipe (
   input  logic                    clock,
   input  logic                    reset,
   input  hpss_pkg::hpss_cfg_type  cfg,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  logic signed [15:0]      in_goal,
   input  logic signed [15:0]      in_yaw,
   input  logic                    in_en,
   output logic                    out_valid,
   input  logic                    out_ready,
   output logic signed [15:0]      out_offset,
   output logic [15:0]             out_error,
   output hpss_pkg::hpss_stat_type stat
);
   import hpss_pkg::*;

   // Stage occupancy and per-stage load enables.
   logic [PIPE_STAGES-1:0] valid_ff;
   logic [PIPE_STAGES-1:0] valid_in;
   logic [PIPE_STAGES-1:0] adv;
   logic [PIPE_STAGES-1:0] ld;

   // Stage 0: input register.
   logic signed [15:0] s0_goal_ff;
   logic signed [15:0] s0_yaw_ff;
   logic               s0_en_ff;

   // Stage 1: heading error and its change since the last enabled transaction.
   logic [15:0]        s1_e_ff;
   logic [15:0]        s1_e_in;
   logic signed [16:0] s1_diff_ff;
   logic signed [16:0] s1_diff_in;
   logic [15:0]        s1_err_ff;
   logic [15:0]        s1_err_in;
   logic               s1_en_ff;
   logic [15:0]        last_error_ff;

   // Stage 2: proportional and derivative products.
   logic [31:0]        s2_prod_p_ff;
   logic [31:0]        s2_prod_p_in;
   logic signed [33:0] s2_prod_d_ff;
   logic signed [33:0] s2_prod_d_in;
   logic [15:0]        s2_err_ff;
   logic               s2_en_ff;

   // Stage 3: sign, magnitude and saturation test of the numerator.
   logic signed [34:0] s3_num;
   logic [34:0]        s3_abs;
   logic               s3_neg_ff;
   logic               s3_big_ff;
   logic [24:0]        s3_abs_lo_ff;
   logic [15:0]        s3_err_ff;
   logic               s3_en_ff;

   // Stage 4: quotient by 1000.
   logic [50:0]        s4_prod;
   logic [15:0]        s4_q_ff;
   logic [15:0]        s4_q_in;
   logic               s4_neg_ff;
   logic               s4_big_ff;
   logic [15:0]        s4_err_ff;
   logic               s4_en_ff;

   // Stage 5: steering offset.
   logic [15:0]        s5_pos_mag;
   logic signed [15:0] s5_delta;
   logic signed [15:0] s5_offset_ff;
   logic signed [15:0] s5_offset_in;
   logic [15:0]        s5_err_ff;
   logic signed [15:0] offset_ff;

   // A stage may load when it is empty or its occupant moves on.
   always_comb begin
      adv[5] = !valid_ff[5] || out_ready;
      adv[4] = !valid_ff[4] || adv[5];
      adv[3] = !valid_ff[3] || adv[4];
      adv[2] = !valid_ff[2] || adv[3];
      adv[1] = !valid_ff[1] || adv[2];
      adv[0] = !valid_ff[0] || adv[1];
      ld[0]  = adv[0] && in_valid;
      ld[1]  = adv[1] && valid_ff[0];
      ld[2]  = adv[2] && valid_ff[1];
      ld[3]  = adv[3] && valid_ff[2];
      ld[4]  = adv[4] && valid_ff[3];
      ld[5]  = adv[5] && valid_ff[4];
      valid_in[0] = adv[0] ? in_valid    : valid_ff[0];
      valid_in[1] = adv[1] ? valid_ff[0] : valid_ff[1];
      valid_in[2] = adv[2] ? valid_ff[1] : valid_ff[2];
      valid_in[3] = adv[3] ? valid_ff[2] : valid_ff[3];
      valid_in[4] = adv[4] ? valid_ff[3] : valid_ff[4];
      valid_in[5] = adv[5] ? valid_ff[4] : valid_ff[5];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Stage 0 captures the accepted transaction.
   always_ff @(posedge clock) begin
      if (ld[0]) begin
         s0_goal_ff <= in_goal;
         s0_yaw_ff  <= in_yaw;
         s0_en_ff   <= in_en;
      end
   end

   // Stage 1: a disabled transaction reports the held error and leaves it unchanged.
   always_comb begin
      s1_e_in    = hpss_heading_err(s0_goal_ff, s0_yaw_ff);
      s1_diff_in = $signed({1'b0, s1_e_in}) - $signed({1'b0, last_error_ff});
      s1_err_in  = s0_en_ff ? s1_e_in : last_error_ff;
   end

   always_ff @(posedge clock) begin
      if (ld[1]) begin
         s1_e_ff    <= s1_e_in;
         s1_diff_ff <= s1_diff_in;
         s1_err_ff  <= s1_err_in;
         s1_en_ff   <= s0_en_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_error_ff <= '0;
      end else if (ld[1] && s0_en_ff) begin
         last_error_ff <= s1_e_in;
      end
   end

   // Stage 2: the two gain products run side by side.
   always_comb begin
      s2_prod_p_in = cfg.gain_p * s1_e_ff;
      s2_prod_d_in = $signed({1'b0, cfg.gain_d}) * s1_diff_ff;
   end

   always_ff @(posedge clock) begin
      if (ld[2]) begin
         s2_prod_p_ff <= s2_prod_p_in;
         s2_prod_d_ff <= s2_prod_d_in;
         s2_err_ff    <= s1_err_ff;
         s2_en_ff     <= s1_en_ff;
      end
   end

   // Stage 3: sum, then split into sign and magnitude so the divide truncates toward zero.
   always_comb begin
      s3_num = $signed({3'b000, s2_prod_p_ff}) + $signed({s2_prod_d_ff[33], s2_prod_d_ff});
      s3_abs = s3_num[34] ? 35'(-s3_num) : 35'(s3_num);
   end

   always_ff @(posedge clock) begin
      if (ld[3]) begin
         s3_neg_ff    <= s3_num[34];
         s3_big_ff    <= (s3_abs >= SAT_NUM);
         s3_abs_lo_ff <= s3_abs[24:0];
         s3_err_ff    <= s2_err_ff;
         s3_en_ff     <= s2_en_ff;
      end
   end

   // Stage 4: magnitude below the saturation point divided by 1000.
   always_comb begin
      s4_prod = s3_abs_lo_ff * RECIP_MULT;
      s4_q_in = s4_prod[RECIP_SHIFT +: 16];
   end

   always_ff @(posedge clock) begin
      if (ld[4]) begin
         s4_q_ff   <= s4_q_in;
         s4_neg_ff <= s3_neg_ff;
         s4_big_ff <= s3_big_ff;
         s4_err_ff <= s3_err_ff;
         s4_en_ff  <= s3_en_ff;
      end
   end

   // Stage 5: saturate, apply the steering sign, and hold the offset when disabled.
   // Only a negative quotient may reach the most negative value before the sign flip,
   // and flipping that value saturates back to the positive limit.
   always_comb begin
      s5_pos_mag = s4_big_ff ? 16'(OFFSET_MAX) : s4_q_ff;
      unique case ({s4_neg_ff, cfg.steer_negate})
         2'b00, 2'b11: s5_delta = $signed(s5_pos_mag);
         2'b01:        s5_delta = -$signed(s5_pos_mag);
         2'b10:        s5_delta = s4_big_ff ? OFFSET_MIN : -$signed(s4_q_ff);
         default:      s5_delta = $signed(s5_pos_mag);
      endcase
      s5_offset_in = s4_en_ff ? s5_delta : offset_ff;
   end

   always_ff @(posedge clock) begin
      if (ld[5]) begin
         s5_offset_ff <= s5_offset_in;
         s5_err_ff    <= s4_err_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= '0;
      end else if (ld[5] && s4_en_ff) begin
         offset_ff <= s5_delta;
      end
   end

   assign in_ready         = adv[0];
   assign out_valid        = valid_ff[5];
   assign out_offset       = s5_offset_ff;
   assign out_error        = s5_err_ff;
   assign stat.stage_valid = valid_ff;

endmodule

>>> hdl/hpss_duty.sv
// Duty stage: adds the steering offset to the neutral duty, applies the window and
// absolute clamps, and holds the result in the response register.
// Depends on hpss_pkg for the configuration struct and on the response channel interface.
module hpss_duty (
   input  logic                   clock,
   input  logic                   reset,
   input  hpss_pkg::hpss_cfg_type cfg,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  logic signed [15:0]     in_offset,
   input  logic [15:0]            in_error,
   hpss_rsp_if.source             rsp
);
   import hpss_pkg::*;

   logic               valid_ff;
   logic               load;
   logic signed [17:0] mid_s;
   logic signed [17:0] hi_s;
   logic signed [17:0] lo_s;
   logic signed [17:0] duty_s;
   logic [15:0]        duty_ff;
   logic [15:0]        duty_in;
   logic [15:0]        err_ff;

   assign in_ready = !valid_ff || rsp.ready;
   assign load     = in_valid && in_ready;

   // Clamp order matters: window first, then floor, and the ceiling last so it wins.
   always_comb begin
      mid_s  = $signed({2'b00, cfg.servo_mid});
      hi_s   = mid_s + $signed({3'b000, cfg.range_up});
      lo_s   = mid_s - $signed({3'b000, cfg.range_down});
      duty_s = mid_s + 18'(in_offset);
      if (duty_s > hi_s) begin
         duty_s = hi_s;
      end
      if (duty_s < lo_s) begin
         duty_s = lo_s;
      end
      if (duty_s <= $signed({2'b00, cfg.duty_floor})) begin
         duty_s = $signed({2'b00, cfg.duty_floor});
      end
      if (duty_s >= $signed({2'b00, cfg.duty_ceiling})) begin
         duty_s = $signed({2'b00, cfg.duty_ceiling});
      end
      duty_in = duty_s[15:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         duty_ff <= duty_in;
         err_ff  <= in_error;
      end
   end

   assign rsp.valid         = valid_ff;
   assign rsp.duty          = duty_ff;
   assign rsp.heading_error = err_ff;

endmodule

>>> hdl/heading_pd_servo_steer.sv
// PD heading controller with servo duty clamping.
// Top level: APB-style register file, six-stage PD pipeline and the duty output stage.
// Depends on hpss_pkg, the channel interfaces, hpss_csr, hpss_pd_pipe and hpss_duty.

// One transaction is accepted per clock while the pipeline is not stalled, and each produces exactly
// one response, which appears on the response channel. The transaction passes seven
// registers: an input register (loaded at the accepting edge), the heading error stage, the
// gain multipliers, the numerator sum, the divide-by-1000 reciprocal multiplier, the offset
// stage that holds the steering offset, and the duty clamp that feeds the response register.
// Results leave in arrival order; when the response side stalls, the stages fill and
// req_chan.ready drops only once every stage holds a transaction. The previous heading error
// and the steering offset update as a transaction passes the heading error and offset stages,
// so back-to-back transactions see each other's state exactly as if handled one at a time.
// Registers are written with a setup and an access cycle at byte address 4*index and should
// only be changed while no transaction is in flight.
module heading_pd_servo_steer (
   input  logic                            clock,
   input  logic                            reset,
   hpss_req_if.sink                        req_chan,
   hpss_rsp_if.source                      rsp_chan,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [hpss_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]                     pwdata,
   output logic [31:0]                     prdata,
   output logic                            pready
);
   import hpss_pkg::*;

   hpss_cfg_type       cfg;
   hpss_stat_type      stat;
   logic               pipe_valid;
   logic               pipe_ready;
   logic signed [15:0] pipe_offset;
   logic [15:0]        pipe_error;
   logic [PIPE_STAGES:0] occupancy;
   logic               req_xfer;
   logic               rsp_xfer;

   // Configuration registers.
   hpss_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // PD computation and the controller state.
   hpss_pd_pipe u_pipe (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .in_valid   (req_chan.valid),
      .in_ready   (req_chan.ready),
      .in_goal    (req_chan.goal_heading),
      .in_yaw     (req_chan.yaw_heading),
      .in_en      (req_chan.pd_enable),
      .out_valid  (pipe_valid),
      .out_ready  (pipe_ready),
      .out_offset (pipe_offset),
      .out_error  (pipe_error),
      .stat       (stat)
   );

   // Duty clamp and response register.
   hpss_duty u_duty (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (pipe_valid),
      .in_ready  (pipe_ready),
      .in_offset (pipe_offset),
      .in_error  (pipe_error),
      .rsp       (rsp_chan)
   );

   // Checks: transactions are neither lost nor duplicated inside the block, and the
   // input side is never held off while there is room somewhere downstream.
   assign occupancy = {rsp_chan.valid, stat.stage_valid};
   assign req_xfer  = req_chan.valid && req_chan.ready;
   assign rsp_xfer  = rsp_chan.valid && rsp_chan.ready;

   a_occ_inc: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && !rsp_xfer) |=> ($countones(occupancy) == $past($countones(occupancy)) + 1))
      else $error("occupancy did not grow after an accepted transaction");

   a_occ_dec: assert property (@(posedge clock) disable iff (reset)
      (!req_xfer && rsp_xfer) |=> ($countones(occupancy) == $past($countones(occupancy)) - 1))
      else $error("occupancy did not shrink after a delivered transaction");

   a_occ_hold: assert property (@(posedge clock) disable iff (reset)
      (req_xfer == rsp_xfer) |=> ($countones(occupancy) == $past($countones(occupancy))))
      else $error("occupancy changed without a matching transaction");

   a_no_false_stall: assert property (@(posedge clock) disable iff (reset)
      (!(&occupancy) || rsp_chan.ready) |-> req_chan.ready)
      else $error("input held off while the pipeline had room");

endmodule
